FILE: design/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TallyW = 3;
  localparam int unsigned EnW    = 4;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [TimeW-1:0]  LongPressRst   = 32'd1000;
  localparam logic [TimeW-1:0]  ClickWindowRst = 32'd300;
  localparam logic [EnW-1:0]    EventEnRst     = 4'hF;
  localparam logic [TallyW-1:0] TallyMax       = 3'd7;

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_LONG   = 3'd1,
    GEST_SINGLE = 3'd2,
    GEST_DOUBLE = 3'd3,
    GEST_TRIPLE = 3'd4
  } gesture_e;

  typedef enum logic [1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_CLICK_WINDOW = 2'd1,
    REG_EVENT_EN     = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] long_press_ms;
    logic [TimeW-1:0] click_window_ms;
    logic [EnW-1:0]   event_enable;
  } bgc_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             button_level;
    logic             edge_seen;
  } bgc_poll_t;

endpackage

FILE: design/bgc_ifs.sv
// ----------------------------------------------------------------------------
// bgc_ifs
// Valid/ready channels for poll beats and gesture beats.
// ----------------------------------------------------------------------------
interface bgc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic        button_level;
  logic        edge_seen;

  modport source (output valid, output time_ms, output button_level, output edge_seen,
                  input ready);
  modport sink (input valid, input time_ms, input button_level, input edge_seen,
                output ready);
endinterface

interface bgc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture_event;

  modport source (output valid, output gesture_event, input ready);
  modport sink (input valid, input gesture_event, output ready);
endinterface

FILE: design/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// APB register file holding long-press time, click window and event enables.
// ----------------------------------------------------------------------------
module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output bgc_cfg_t         cfg_o
);

  bgc_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_LONG_PRESS:   cfg_d.long_press_ms   = pwdata;
        REG_CLICK_WINDOW: cfg_d.click_window_ms = pwdata;
        REG_EVENT_EN:     cfg_d.event_enable    = pwdata[EnW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_PRESS:   prdata = cfg_q.long_press_ms;
      REG_CLICK_WINDOW: prdata = cfg_q.click_window_ms;
      REG_EVENT_EN:     prdata = {{(DataW-EnW){1'b0}}, cfg_q.event_enable};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms   <= LongPressRst;
      cfg_q.click_window_ms <= ClickWindowRst;
      cfg_q.event_enable    <= EventEnRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/bgc_core.sv
// ----------------------------------------------------------------------------
// bgc_core
// Press/release tracking and gesture decision for one poll beat per cycle while step_i is high.
// ----------------------------------------------------------------------------
module bgc_core
  import bgc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  bgc_poll_t poll_i,
  input  bgc_cfg_t  cfg_i,
  output gesture_e  event_o
);

  logic              pressing_q, pressing_d;
  logic              long_fired_q, long_fired_d;
  logic [TimeW-1:0]  press_start_q, press_start_d;
  logic [TimeW-1:0]  release_time_q, release_time_d;
  logic [TallyW-1:0] tally_q, tally_d;

  logic              level_low;
  logic              press_start;
  logic              pressing_1;
  logic              long_fired_1;
  logic              long_hit;
  logic              release_hit;
  logic              report;
  logic [TimeW-1:0]  hold_time;
  logic [TimeW-1:0]  quiet_time;

  assign level_low    = ~poll_i.button_level;
  assign press_start  = poll_i.edge_seen & level_low & ~pressing_q;
  assign pressing_1   = pressing_q | press_start;
  assign long_fired_1 = long_fired_q & ~press_start;
  assign press_start_d = press_start ? poll_i.time_ms : press_start_q;
  assign hold_time    = poll_i.time_ms - press_start_d;
  assign long_hit     = pressing_1 & level_low & ~long_fired_1 &
                        (hold_time > cfg_i.long_press_ms);
  assign long_fired_d = long_fired_1 | long_hit;
  assign release_hit  = pressing_1 & ~level_low;
  assign pressing_d   = pressing_1 & level_low;
  assign release_time_d = release_hit ? poll_i.time_ms : release_time_q;
  assign quiet_time   = poll_i.time_ms - release_time_d;

  logic [TallyW-1:0] tally_1;
  assign tally_1 = (release_hit && !long_fired_d && tally_q != TallyMax) ?
                   tally_q + TallyW'(1) : tally_q;
  assign report  = (tally_1 != '0) & ~pressing_d & (quiet_time > cfg_i.click_window_ms);
  assign tally_d = report ? '0 : tally_1;

  always_comb begin
    event_o = GEST_NONE;
    if (long_hit && cfg_i.event_enable[0]) begin
      event_o = GEST_LONG;
    end
    if (report) begin
      case (tally_1)
        3'd1: if (cfg_i.event_enable[1]) event_o = GEST_SINGLE;
        3'd2: if (cfg_i.event_enable[2]) event_o = GEST_DOUBLE;
        3'd3: if (cfg_i.event_enable[3]) event_o = GEST_TRIPLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressing_q     <= 1'b0;
      long_fired_q   <= 1'b0;
      press_start_q  <= '0;
      release_time_q <= '0;
      tally_q        <= '0;
    end else if (step_i) begin
      pressing_q     <= pressing_d;
      long_fired_q   <= long_fired_d;
      press_start_q  <= press_start_d;
      release_time_q <= release_time_d;
      tally_q        <= tally_d;
    end
  end

endmodule

FILE: design/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies long press and single/double/triple clicks from button polls.
//
//   channel   dir  beat contents                          handshake
//   in_if     in   time_ms, button_level, edge_seen       valid/ready
//   out_if    out  gesture_event (one per poll)           valid/ready
//   apb       in   long_press_ms, click_window_ms, enable psel/penable
//
// one poll per cycle sustained while out_if is not stalled; the result is registered
// a poll register feeds the classifier, a result register holds the gesture
// out_if stall holds the result; in_if keeps taking polls until both stages fill
// reset clears state and config to defaults; no clearing pass
// ----------------------------------------------------------------------------
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bgc_in_if.sink           in_if,
  bgc_out_if.source        out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  bgc_cfg_t  cfg;
  bgc_poll_t poll_q;
  logic      poll_vld_q;
  logic      res_vld_q;
  gesture_e  res_q, res_d;
  logic      res_free;
  logic      step;

  assign res_free     = ~res_vld_q | out_if.ready;
  assign step         = poll_vld_q & res_free;
  assign in_if.ready  = ~poll_vld_q | res_free;
  assign out_if.valid = res_vld_q;
  assign out_if.gesture_event = res_q;

  bgc_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .poll_i  (poll_q),
    .cfg_i   (cfg),
    .event_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_if.ready) begin
        poll_vld_q <= in_if.valid;
      end
      if (res_free) begin
        res_vld_q <= poll_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      poll_q.time_ms      <= in_if.time_ms;
      poll_q.button_level <= in_if.button_level;
      poll_q.edge_seen    <= in_if.edge_seen;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: design/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_port_checks
// Port-level checks for the button gesture classifier.
// ----------------------------------------------------------------------------
module bgc_port_checks
  import bgc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       gesture_event,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [AddrW-1:0] paddr,
  input logic [DataW-1:0] pwdata,
  input logic [DataW-1:0] prdata
);

  logic en_wr, en_rd;
  assign en_wr = psel & penable & pwrite & (paddr == {REG_EVENT_EN, 2'b00});
  assign en_rd = psel & penable & ~pwrite & (paddr == {REG_EVENT_EN, 2'b00});

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(gesture_event))
    else $error("gesture beat changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> gesture_event <= 3'd4)
    else $error("gesture code out of range");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("gesture beat without a poll two cycles earlier");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_wr ##1 en_rd) |-> prdata[DataW-1:EnW] == '0 &&
                          prdata[EnW-1:0] == $past(pwdata[EnW-1:0]))
    else $error("event enable readback mismatch");

endmodule

bind button_gesture_classifier bgc_port_checks u_bgc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .gesture_event (out_if.gesture_event),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

FILE: bench/bgc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bgc_checker
// Watches the poll, gesture and register ports of the gesture classifier,
// predicts one gesture per accepted poll and compares it against the
// gesture beats in order. Reports the error count and the number of
// gestures still outstanding.
// ----------------------------------------------------------------------------
module bgc_checker
  import bgc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bgc_in_if                in_mon,
  bgc_out_if               out_mon,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int unsigned      err_cnt_o,
  output int unsigned      pending_o
);

  bgc_cfg_t          cfg;
  logic              pressing;
  logic              long_fired;
  logic [TimeW-1:0]  press_start;
  logic [TimeW-1:0]  release_at;
  logic [TallyW-1:0] click_tally;
  gesture_e          gesture_q[$];
  int unsigned       mismatches;

  function automatic gesture_e classify_poll(bgc_poll_t poll);
    gesture_e         gest;
    logic             level_low;
    logic [TimeW-1:0] held_ms;
    logic [TimeW-1:0] quiet_ms;
    gest      = GEST_NONE;
    level_low = ~poll.button_level;

    if (poll.edge_seen && level_low && !pressing) begin
      pressing    = 1'b1;
      press_start = poll.time_ms;
      long_fired  = 1'b0;
    end

    held_ms = poll.time_ms - press_start;
    if (pressing && level_low && !long_fired && held_ms > cfg.long_press_ms) begin
      long_fired = 1'b1;
      if (cfg.event_enable[0]) gest = GEST_LONG;
    end

    if (pressing && !level_low) begin
      pressing   = 1'b0;
      release_at = poll.time_ms;
      if (!long_fired && click_tally < TallyMax) click_tally = click_tally + 1'b1;
    end

    quiet_ms = poll.time_ms - release_at;
    if (click_tally != '0 && !pressing && quiet_ms > cfg.click_window_ms) begin
      case (click_tally)
        3'd1: if (cfg.event_enable[1]) gest = GEST_SINGLE;
        3'd2: if (cfg.event_enable[2]) gest = GEST_DOUBLE;
        3'd3: if (cfg.event_enable[3]) gest = GEST_TRIPLE;
        default: ;
      endcase
      click_tally = '0;
    end
    return gest;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gesture_e  want;
    bgc_poll_t poll;
    if (!rst_ni) begin
      cfg.long_press_ms   = LongPressRst;
      cfg.click_window_ms = ClickWindowRst;
      cfg.event_enable    = EventEnRst;
      pressing            = 1'b0;
      long_fired          = 1'b0;
      press_start         = '0;
      release_at          = '0;
      click_tally         = '0;
      gesture_q.delete();
      mismatches          = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrW-1:2]))
          REG_LONG_PRESS:   cfg.long_press_ms   = pwdata[TimeW-1:0];
          REG_CLICK_WINDOW: cfg.click_window_ms = pwdata[TimeW-1:0];
          REG_EVENT_EN:     cfg.event_enable    = pwdata[EnW-1:0];
          default: ;
        endcase
      end

      // compare before pushing: a beat leaving now belongs to an older poll
      if (out_mon.valid && out_mon.ready) begin
        if (gesture_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected gesture beat: got %0d", out_mon.gesture_event);
          end
          mismatches++;
        end else begin
          want = gesture_q.pop_front();
          if (out_mon.gesture_event !== want) begin
            if (mismatches < 10) begin
              $display("gesture mismatch: expected %0d (%s), got %0d",
                       want, want.name(), out_mon.gesture_event);
            end
            mismatches++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        poll.time_ms      = in_mon.time_ms;
        poll.button_level = in_mon.button_level;
        poll.edge_seen    = in_mon.edge_seen;
        gesture_q.push_back(classify_poll(poll));
      end
    end
    err_cnt_o <= mismatches;
    pending_o <= gesture_q.size();
  end

endmodule

FILE: bench/button_gesture_classifier_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_test
// Drives button polls and register writes into the gesture classifier:
// a directed run through clicks, long press, timestamp wrap and ignored
// inputs, then random press/release bursts under six register settings
// with varying back-pressure. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module button_gesture_classifier_test;
  import bgc_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned PollsPerCfg  = 100;
  localparam int unsigned LongHoldOff  = 80;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int unsigned      err_cnt;
  int unsigned      pending;
  int unsigned      cycles;
  int unsigned      polls_sent;
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  int unsigned      rx_hold;
  logic [TimeW-1:0] now_ms;
  logic [TimeW-1:0] long_ms;
  logic [TimeW-1:0] click_gap_ms;

  bgc_in_if  in_if ();
  bgc_out_if out_if ();

  button_gesture_classifier u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bgc_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // gesture sink: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_poll(logic [TimeW-1:0] t, logic level, logic edge_bit);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.time_ms      <= t;
    in_if.button_level <= level;
    in_if.edge_seen    <= edge_bit;
    do @(posedge clk); while (!in_if.ready);
    polls_sent++;
  endtask

  task automatic apb_write(reg_idx_e idx, logic [DataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(logic [TimeW-1:0] lp, logic [TimeW-1:0] cw, logic [EnW-1:0] en);
    long_ms      = lp;
    click_gap_ms = cw;
    apb_write(REG_LONG_PRESS, lp);
    apb_write(REG_CLICK_WINDOW, cw);
    apb_write(REG_EVENT_EN, DataW'(en));
  endtask

  // spread of gaps around a threshold: at, just past, just short, tiny, anything
  function automatic logic [TimeW-1:0] pick_gap(logic [TimeW-1:0] limit);
    case ($urandom_range(5))
      0: return limit;
      1: return limit + 32'd1;
      2: return limit - 32'($urandom_range(1, 3));
      3: return $urandom;
      default: return 32'($urandom_range(0, 60));
    endcase
  endfunction

  task automatic run_gestures(int unsigned n);
    int unsigned      target;
    int unsigned      clicks;
    logic [TimeW-1:0] start;
    target = polls_sent + n;
    while (polls_sent < target) begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(2))
            0: now_ms = $urandom;
            1: now_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
            default: now_ms = now_ms + 32'($urandom_range(0, 1000));
          endcase
          send_poll(now_ms, 1'($urandom), 1'($urandom));
        end
        8, 9: begin
          now_ms = now_ms + 32'($urandom_range(0, 20));
          start  = now_ms;
          send_poll(now_ms, 1'b0, 1'b1);
          repeat ($urandom_range(1, 3)) begin
            now_ms = start + pick_gap(long_ms);
            send_poll(now_ms, 1'b0, 1'($urandom));
          end
          now_ms = now_ms + 32'($urandom_range(0, 30));
          send_poll(now_ms, 1'b1, 1'b1);
          now_ms = now_ms + pick_gap(click_gap_ms);
          send_poll(now_ms, 1'b1, 1'b0);
        end
        default: begin
          clicks = $urandom_range(1, 9);
          repeat (clicks) begin
            now_ms = now_ms + 32'($urandom_range(0, 20));
            send_poll(now_ms, 1'b0, 1'b1);
            if ($urandom_range(3) == 0) begin
              now_ms = now_ms + pick_gap(long_ms);
              send_poll(now_ms, 1'b0, 1'($urandom));
            end
            now_ms = now_ms + 32'($urandom_range(0, 30));
            send_poll(now_ms, 1'b1, $urandom_range(7) != 0);
            if ($urandom_range(3) == 0) begin
              now_ms = now_ms + pick_gap(click_gap_ms);
              send_poll(now_ms, 1'b1, 1'b0);
            end
          end
          now_ms = now_ms + pick_gap(click_gap_ms);
          send_poll(now_ms, 1'b1, 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.time_ms      = '0;
    in_if.button_level = 1'b1;
    in_if.edge_seen    = 1'b0;
    polls_sent         = 0;
    rx_hold            = 0;
    tx_idle_pct        = 6;
    rx_idle_pct        = 74;
    now_ms             = '0;
    long_ms            = LongPressRst;
    click_gap_ms       = ClickWindowRst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset register values
    send_poll(32'd0, 1'b1, 1'b1);             // edge with level high
    send_poll(32'd10, 1'b0, 1'b0);            // low without edge
    send_poll(32'd20, 1'b0, 1'b1);
    send_poll(32'd120, 1'b1, 1'b1);
    send_poll(32'd420, 1'b1, 1'b0);           // exactly the window
    send_poll(32'd421, 1'b1, 1'b0);           // single
    send_poll(32'd500, 1'b0, 1'b1);
    send_poll(32'd550, 1'b1, 1'b1);
    send_poll(32'd600, 1'b0, 1'b1);
    send_poll(32'd650, 1'b1, 1'b1);
    send_poll(32'd951, 1'b1, 1'b0);           // double
    send_poll(32'd1000, 1'b0, 1'b1);
    send_poll(32'd1010, 1'b1, 1'b1);
    send_poll(32'd1020, 1'b0, 1'b1);
    send_poll(32'd1030, 1'b1, 1'b1);
    send_poll(32'd1040, 1'b0, 1'b1);
    send_poll(32'd1050, 1'b1, 1'b1);
    send_poll(32'd1351, 1'b1, 1'b0);          // triple
    send_poll(32'hFFFF_FF00, 1'b0, 1'b1);     // press just before wrap
    send_poll(32'h0000_00E8, 1'b0, 1'b0);
    send_poll(32'h0000_03E8, 1'b0, 1'b0);     // long, across wrap
    send_poll(32'h0000_0400, 1'b1, 1'b1);
    send_poll(32'h0000_0600, 1'b1, 1'b0);
    now_ms = 32'h0000_0600;
    drain_results();
    apb_write(REG_NONE, $urandom);            // unmapped register, ignored

    for (int s = 0; s < 6; s++) begin
      tx_idle_pct = (s < 2) ? 6 : (s < 4) ? 74 : 0;
      rx_idle_pct = (s < 2) ? 74 : (s < 4) ? 6 : 0;
      case (s)
        0: apply_setting(32'd0, 32'd0, 4'hF);
        1: apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
        2: apply_setting(32'd50, 32'd40, 4'($urandom));
        3: apply_setting($urandom_range(1, 2000), $urandom_range(1, 500), 4'($urandom));
        4: apply_setting(LongPressRst, ClickWindowRst, 4'b1010);
        default: apply_setting($urandom, $urandom, EventEnRst);
      endcase
      if (s == 5) rx_hold = LongHoldOff;
      run_gestures(PollsPerCfg);
      drain_results();
    end

    if (err_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: button_gesture_classifier.f
design/bgc_pkg.sv
design/bgc_ifs.sv
design/bgc_cfg_regs.sv
design/bgc_core.sv
design/button_gesture_classifier.sv
design/bgc_checker.sv
bench/bgc_checker.sv
bench/button_gesture_classifier_test.sv
